/* rtl/track_point_linear_resampler_core_macros.svh */
// Assertion helpers; clk and arst_n are taken from the enclosing module.
`ifndef TRACK_POINT_LINEAR_RESAMPLER_CORE_MACROS_SVH
`define TRACK_POINT_LINEAR_RESAMPLER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Condition holds at every clock edge out of reset.
`define TPLR_ASSERT_HOLDS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// Antecedent implies the consequent in the following cycle.
`define TPLR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TPLR_ASSERT_HOLDS(lbl, cond, msg)
`define TPLR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/tplr_pkg.sv */
package tplr_pkg;

	localparam int TIME_W        = 32;
	localparam int COORD_W       = 32;
	localparam int TFRAC_W       = 8;
	localparam int SEC_W         = TIME_W - TFRAC_W;
	localparam int DELTA_W       = COORD_W + 1;
	localparam int BITS_PER_STEP = 3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_PREV,
		ST_MUL,
		ST_DIV,
		ST_EMIT,
		ST_LAST
	} state_t;

endpackage

/* rtl/track_point_linear_resampler_core.sv */
// Track point resampler: takes one track point per item (time Q24.8, x/y signed Q16.16) and
// holds the previous point. Each point after the first emits the held point, then one
// point per whole second strictly between the two floored times, x/y linearly
// interpolated with truncation toward zero (prev + trunc(k*delta/gap)). A point marked
// tlast is also emitted itself as the end of track, and the held point is dropped; a lone
// tlast point comes out flagged too_few_points. Gaps above MAX_GAP emit only MAX_GAP-1
// intermediates, all results of that item flagged gap_clipped. tready is high only when
// the sequencer is idle. Each intermediate takes two divisions (x then y) on one shared
// divider that retires 3 quotient bits per cycle from a dividend of DW bits, where DW is
// 33+clog2(MAX_GAP) rounded up to a multiple of 3. The output register lets the next item
// be taken while the last result still waits.
`include "track_point_linear_resampler_core_macros.svh"

module track_point_linear_resampler_core #(
	// Largest gap in seconds that is filled completely (2..63)
	parameter int MAX_GAP = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [31:0] point_time, [63:32] point_x, [95:64] point_y
	input  logic [95:0] s_axis_tdata,
	// final_point
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [31:0] out_time, [63:32] out_x, [95:64] out_y
	output logic [95:0] m_axis_tdata,
	// run_last
	output logic        m_axis_tlast,
	// [0] track_end, [1] too_few_points, [2] gap_clipped
	output logic [2:0]  m_axis_tuser
);

	localparam int TW  = tplr_pkg::TIME_W;
	localparam int CRW = tplr_pkg::COORD_W;
	localparam int FW  = tplr_pkg::TFRAC_W;
	localparam int SW  = tplr_pkg::SEC_W;
	localparam int DLW = tplr_pkg::DELTA_W;
	localparam int BPS = tplr_pkg::BITS_PER_STEP;
	// k counter width, holds up to MAX_GAP-1
	localparam int KW  = $clog2(MAX_GAP);
	localparam int PW  = DLW + KW;
	// dividend padded to whole divider steps
	localparam int DW  = ((PW + BPS - 1) / BPS) * BPS;

	tplr_pkg::state_t state_q, state_d;

	// control
	logic           accept;
	logic           slot_free;
	logic           out_load;
	logic           div_start;
	logic           div_done;
	logic           keep_point;
	logic           drop_point;
	logic           have_prev_q;
	logic           out_valid_q;
	logic [KW-1:0]  k_q;
	logic           sel_q;

	// held and current points
	logic [TW-1:0]  prev_t_q, cur_t_q;
	logic [CRW-1:0] prev_x_q, cur_x_q;
	logic [CRW-1:0] prev_y_q, cur_y_q;
	logic           fin_q;
	logic           few_q;

	// per-segment setup
	logic [SW:0]    gap;
	logic [DLW-1:0] dx, dy;
	logic [SW-1:0]  divisor_q;
	logic [KW-1:0]  cnt_q;
	logic           clip_q;
	logic [DLW-1:0] dmx_q, dmy_q;
	logic           negx_q, negy_q;

	// division path
	logic [PW-1:0]  prod;
	logic [DW-1:0]  div_dividend;
	logic [DW-1:0]  div_quo;
	logic [CRW-1:0] q32;
	logic [CRW-1:0] interp;
	logic [CRW-1:0] ix_q, iy_q;
	logic [SW-1:0]  sec_k;

	// output register
	logic [TW-1:0]  o_t_d, o_t_q;
	logic [CRW-1:0] o_x_d, o_x_q;
	logic [CRW-1:0] o_y_d, o_y_q;
	logic           o_last_d, o_last_q;
	logic           o_end_d, o_end_q;
	logic           o_few_d, o_few_q;
	logic           o_clip_d, o_clip_q;

	assign s_axis_tready = (state_q == tplr_pkg::ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign slot_free     = !out_valid_q || m_axis_tready;

	// floored-second gap and signed deltas, latched in ST_SETUP
	assign gap = {1'b0, cur_t_q[TW-1:FW]} - {1'b0, prev_t_q[TW-1:FW]};
	assign dx  = {cur_x_q[CRW-1], cur_x_q} - {prev_x_q[CRW-1], prev_x_q};
	assign dy  = {cur_y_q[CRW-1], cur_y_q} - {prev_y_q[CRW-1], prev_y_q};

	// |k*delta|, registered inside the divider on start
	assign prod         = PW'(k_q) * PW'(sel_q ? dmy_q : dmx_q);
	assign div_dividend = DW'(prod);

	// quotient magnitude stays below 2^32, sign restored here
	assign q32    = div_quo[CRW-1:0];
	assign interp = sel_q ? (prev_y_q + (negy_q ? (~q32 + 1'b1) : q32))
	                      : (prev_x_q + (negx_q ? (~q32 + 1'b1) : q32));
	assign sec_k  = prev_t_q[TW-1:FW] + SW'(k_q);

	tplr_div #(
		.DW(DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (divisor_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// sequencer
	always_comb begin
		state_d    = state_q;
		out_load   = 1'b0;
		div_start  = 1'b0;
		keep_point = 1'b0;
		drop_point = 1'b0;
		case (state_q)
			tplr_pkg::ST_IDLE: begin
				if (accept) begin
					if (have_prev_q) begin
						state_d = tplr_pkg::ST_SETUP;
					end else if (s_axis_tlast) begin
						state_d = tplr_pkg::ST_LAST;
					end
				end
			end
			tplr_pkg::ST_SETUP: begin
				state_d = tplr_pkg::ST_PREV;
			end
			tplr_pkg::ST_PREV: begin
				if (slot_free) begin
					out_load = 1'b1;
					if (cnt_q != '0) begin
						state_d = tplr_pkg::ST_MUL;
					end else if (fin_q) begin
						state_d = tplr_pkg::ST_LAST;
					end else begin
						keep_point = 1'b1;
						state_d    = tplr_pkg::ST_IDLE;
					end
				end
			end
			tplr_pkg::ST_MUL: begin
				div_start = 1'b1;
				state_d   = tplr_pkg::ST_DIV;
			end
			tplr_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = sel_q ? tplr_pkg::ST_EMIT : tplr_pkg::ST_MUL;
				end
			end
			tplr_pkg::ST_EMIT: begin
				if (slot_free) begin
					out_load = 1'b1;
					if (k_q != cnt_q) begin
						state_d = tplr_pkg::ST_MUL;
					end else if (fin_q) begin
						state_d = tplr_pkg::ST_LAST;
					end else begin
						keep_point = 1'b1;
						state_d    = tplr_pkg::ST_IDLE;
					end
				end
			end
			tplr_pkg::ST_LAST: begin
				if (slot_free) begin
					out_load   = 1'b1;
					drop_point = 1'b1;
					state_d    = tplr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tplr_pkg::ST_IDLE;
			end
		endcase
	end

	// result select
	always_comb begin
		o_t_d    = cur_t_q;
		o_x_d    = cur_x_q;
		o_y_d    = cur_y_q;
		o_last_d = 1'b1;
		o_end_d  = 1'b1;
		o_few_d  = few_q;
		o_clip_d = clip_q;
		case (state_q)
			tplr_pkg::ST_PREV: begin
				o_t_d    = prev_t_q;
				o_x_d    = prev_x_q;
				o_y_d    = prev_y_q;
				o_last_d = (cnt_q == '0) && !fin_q;
				o_end_d  = 1'b0;
				o_few_d  = 1'b0;
			end
			tplr_pkg::ST_EMIT: begin
				o_t_d    = {sec_k, {FW{1'b0}}};
				o_x_d    = ix_q;
				o_y_d    = iy_q;
				o_last_d = (k_q == cnt_q) && !fin_q;
				o_end_d  = 1'b0;
				o_few_d  = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tplr_pkg::ST_IDLE;
			have_prev_q <= 1'b0;
			out_valid_q <= 1'b0;
			k_q         <= '0;
			sel_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && !have_prev_q && !s_axis_tlast) begin
				have_prev_q <= 1'b1;
			end else if (drop_point) begin
				have_prev_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == tplr_pkg::ST_SETUP) begin
				k_q   <= KW'(1);
				sel_q <= 1'b0;
			end else begin
				if (div_done) begin
					sel_q <= !sel_q;
				end
				if (out_load && state_q == tplr_pkg::ST_EMIT) begin
					k_q <= k_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_t_q <= s_axis_tdata[TW-1:0];
			cur_x_q <= s_axis_tdata[TW+CRW-1:TW];
			cur_y_q <= s_axis_tdata[TW+2*CRW-1:TW+CRW];
			fin_q   <= s_axis_tlast;
			few_q   <= !have_prev_q;
			clip_q  <= 1'b0;
			cnt_q   <= '0;
		end
		if (accept && !have_prev_q && !s_axis_tlast) begin
			prev_t_q <= s_axis_tdata[TW-1:0];
			prev_x_q <= s_axis_tdata[TW+CRW-1:TW];
			prev_y_q <= s_axis_tdata[TW+2*CRW-1:TW+CRW];
		end else if (keep_point) begin
			prev_t_q <= cur_t_q;
			prev_x_q <= cur_x_q;
			prev_y_q <= cur_y_q;
		end
		if (state_q == tplr_pkg::ST_SETUP) begin
			divisor_q <= gap[SW-1:0];
			if (!gap[SW] && gap[SW-1:0] > SW'(MAX_GAP)) begin
				clip_q <= 1'b1;
				cnt_q  <= KW'(MAX_GAP - 1);
			end else if (!gap[SW] && gap[SW-1:0] > SW'(1)) begin
				cnt_q <= gap[KW-1:0] - 1'b1;
			end else begin
				cnt_q <= '0;
			end
			negx_q <= dx[DLW-1];
			negy_q <= dy[DLW-1];
			dmx_q  <= dx[DLW-1] ? (~dx + 1'b1) : dx;
			dmy_q  <= dy[DLW-1] ? (~dy + 1'b1) : dy;
		end
		if (div_done) begin
			if (sel_q) begin
				iy_q <= interp;
			end else begin
				ix_q <= interp;
			end
		end
		if (out_load) begin
			o_t_q    <= o_t_d;
			o_x_q    <= o_x_d;
			o_y_q    <= o_y_d;
			o_last_q <= o_last_d;
			o_end_q  <= o_end_d;
			o_few_q  <= o_few_d;
			o_clip_q <= o_clip_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {o_y_q, o_x_q, o_t_q};
	assign m_axis_tlast  = o_last_q;
	assign m_axis_tuser  = {o_clip_q, o_few_q, o_end_q};

	`TPLR_ASSERT_HOLDS(a_div_done_in_div, !div_done || state_q == tplr_pkg::ST_DIV, "divider done outside ST_DIV")
	`TPLR_ASSERT_HOLDS(a_k_in_range, state_q != tplr_pkg::ST_MUL || (k_q != '0 && k_q <= cnt_q), "k out of range")
	`TPLR_ASSERT_NEXT(a_end_drops_prev, out_load && o_end_d, !have_prev_q, "held point kept after track end")
	`TPLR_ASSERT_HOLDS(a_few_not_clipped, !out_valid_q || !(o_few_q && o_clip_q), "lone point marked clipped")

endmodule

/* rtl/tplr_div.sv */
// Unsigned restoring divider, BITS_PER_STEP quotient bits per cycle.
module tplr_div #(
	parameter int DW = 39
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [DW-1:0]               dividend,
	input  logic [tplr_pkg::SEC_W-1:0]  divisor,
	output logic                        done,
	output logic [DW-1:0]               quotient
);

	localparam int SW    = tplr_pkg::SEC_W;
	localparam int BPS   = tplr_pkg::BITS_PER_STEP;
	localparam int STEPS = DW / BPS;
	localparam int CW    = $clog2(STEPS);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [SW-1:0] rem_q;
	logic [SW-1:0] div_q;
	logic [DW-1:0] quo_q;
	logic [SW-1:0] rem_d;
	logic [DW-1:0] quo_d;

	// shift-subtract steps, chained combinationally
	always_comb begin
		logic [SW:0]   r_ext;
		logic [SW-1:0] r;
		logic [DW-1:0] q;
		r = rem_q;
		q = quo_q;
		r_ext = '0;
		for (int i = 0; i < BPS; i++) begin
			r_ext = {r, q[DW-1]};
			q = {q[DW-2:0], 1'b0};
			if (r_ext >= {1'b0, div_q}) begin
				r_ext = r_ext - {1'b0, div_q};
				q[0] = 1'b1;
			end
			r = r_ext[SW-1:0];
		end
		rem_d = r;
		quo_d = q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= quo_d;
			rem_q <= rem_d;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* verif/testbench.sv */
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_GAP_TB  = 63;
	localparam int RANDOM_PTS  = 290;
	localparam int DRAIN_CYC   = 2100;
	localparam int HOLDOFF_CYC = 600;

	// One emitted track point as it should leave the block
	typedef struct {
		logic [tplr_pkg::TIME_W-1:0]  t;
		logic [tplr_pkg::COORD_W-1:0] x;
		logic [tplr_pkg::COORD_W-1:0] y;
		bit                           run_last;
		bit                           track_end;
		bit                           few;
		bit                           clip;
	} track_point_t;

	// Resampling predictor plus the queue of points still owed by the block
	class resample_scoreboard;
		logic [tplr_pkg::TIME_W-1:0]  held_time;
		logic [tplr_pkg::COORD_W-1:0] held_x;
		logic [tplr_pkg::COORD_W-1:0] held_y;
		bit                           holding;
		track_point_t                 owed_q[$];
		int                           errors;
		int                           points_in;
		int                           points_out;
		int                           lone_tracks;
		int                           clipped_segments;
		int                           fill_points;

		function void drop_track();
			held_time = '0;
			held_x    = '0;
			held_y    = '0;
			holding   = 1'b0;
		endfunction

		function void owe(logic [31:0] t, logic [31:0] x, logic [31:0] y,
				bit tend, bit few, bit clip);
			track_point_t p;
			p.t         = t;
			p.x         = x;
			p.y         = y;
			p.run_last  = 1'b0;
			p.track_end = tend;
			p.few       = few;
			p.clip      = clip;
			owed_q.insert(owed_q.size(), p);
		endfunction

		// prev + trunc(k*delta/gap), signed 64-bit math truncates toward zero
		function logic [31:0] lerp(logic [31:0] a, logic [31:0] b, longint k, longint gap);
			longint av;
			longint bv;
			av = longint'($signed(a));
			bv = longint'($signed(b));
			return 32'(av + (k * (bv - av)) / gap);
		endfunction

		function void note_point(logic [31:0] t, logic [31:0] x, logic [31:0] y, bit fin);
			longint s0;
			longint s1;
			longint gap;
			longint cnt;
			bit     clip;
			points_in++;
			if (!holding) begin
				if (fin) begin
					// lone point: echoed back flagged as too few points
					owe(t, x, y, 1'b1, 1'b1, 1'b0);
					owed_q[owed_q.size()-1].run_last = 1'b1;
					lone_tracks++;
					drop_track();
				end else begin
					held_time = t;
					held_x    = x;
					held_y    = y;
					holding   = 1'b1;
				end
				return;
			end
			s0   = longint'(held_time >> tplr_pkg::TFRAC_W);
			s1   = longint'(t >> tplr_pkg::TFRAC_W);
			gap  = s1 - s0;
			cnt  = (gap > 1) ? gap - 1 : 0;
			clip = 1'b0;
			if (gap > MAX_GAP_TB) begin
				clip = 1'b1;
				cnt  = MAX_GAP_TB - 1;
				clipped_segments++;
			end
			owe(held_time, held_x, held_y, 1'b0, 1'b0, clip);
			for (longint k = 1; k <= cnt; k++) begin
				owe(32'((s0 + k) << tplr_pkg::TFRAC_W), lerp(held_x, x, k, gap),
					lerp(held_y, y, k, gap), 1'b0, 1'b0, clip);
				fill_points++;
			end
			if (fin) begin
				owe(t, x, y, 1'b1, 1'b0, clip);
				drop_track();
			end else begin
				held_time = t;
				held_x    = x;
				held_y    = y;
			end
			owed_q[owed_q.size()-1].run_last = 1'b1;
		endfunction

		function void cmp(string what, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s expected %h actual %h", $time, what, want, got);
			end
		endfunction

		function void check_point(logic [95:0] data, logic last, logic [2:0] flags);
			track_point_t p;
			points_out++;
			if (owed_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected point expected none actual %h last %b flags %b",
					$time, data, last, flags);
				return;
			end
			p = owed_q.pop_front();
			cmp("out_time", p.t, data[31:0]);
			cmp("out_x", p.x, data[63:32]);
			cmp("out_y", p.y, data[95:64]);
			cmp("run_last", 32'(p.run_last), 32'(last));
			cmp("track_end", 32'(p.track_end), 32'(flags[0]));
			cmp("too_few_points", 32'(p.few), 32'(flags[1]));
			cmp("gap_clipped", 32'(p.clip), 32'(flags[2]));
		endfunction
	endclass

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata  = '0;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic [2:0]  m_axis_tuser;

	resample_scoreboard sb;
	int                 sent_count;
	int                 directed_count;

	track_point_linear_resampler_core #(
		.MAX_GAP(MAX_GAP_TB)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

	always #6 clk = ~clk;

	// Hard stop, far beyond the slowest legal run (64 results per item, full stalls)
	initial begin
		#50_000_000;
		$display("track_point_linear_resampler_core: mismatch");
		$finish;
	end

	// Offer one point after a random gap; tvalid stays up across back-to-back items.
	// Every fourth batch of 32 items goes without gaps.
	task automatic send_point(logic [31:0] t, logic [31:0] x, logic [31:0] y, bit fin);
		int pause;
		pause = ((sent_count / 32) % 4 == 3) ? 0 : $urandom_range(0, 14);
		if (pause > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {y, x, t};
		s_axis_tlast  <= fin;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_point(t, x, y, fin);
		sent_count++;
	endtask

	// Random tracks: mostly forward time with small steps and nearby coordinates,
	// some near or past the gap limit, some backwards, some fully random values.
	task automatic send_random_track();
		int          len;
		int          pick;
		logic [31:0] t;
		logic [31:0] x;
		logic [31:0] y;
		logic [23:0] sec;
		len = $urandom_range(1, 8);
		t   = $urandom;
		x   = $urandom;
		y   = $urandom;
		for (int i = 0; i < len; i++) begin
			if (i > 0) begin
				sec  = t[31:8];
				pick = $urandom_range(0, 99);
				if (pick < 60)
					sec = sec + 24'($urandom_range(0, 4));
				else if (pick < 80)
					sec = sec + 24'($urandom_range(5, 20));
				else if (pick < 88)
					sec = sec + 24'($urandom_range(MAX_GAP_TB - 3, MAX_GAP_TB + 3));
				else if (pick < 94)
					sec = sec - 24'($urandom_range(1, 10));
				else
					sec = 24'($urandom);
				t = {sec, 8'($urandom_range(0, 255))};
				if ($urandom_range(0, 9) < 7) begin
					x = x + 32'($signed(21'($urandom)));
					y = y + 32'($signed(21'($urandom)));
				end else begin
					x = $urandom;
					y = $urandom;
				end
			end
			send_point(t, x, y, i == len - 1);
		end
	endtask

	// Output side: random ready gaps, a quiet band, and one long hold-off that
	// backs the block up into its input.
	initial begin
		int  pause;
		bit  held_off;
		held_off = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held_off && sb.points_out >= 60) begin
				held_off = 1'b1;
				pause    = HOLDOFF_CYC;
			end else if ((sb.points_out / 50) % 3 == 1) begin
				pause = 0;
			end else begin
				pause = $urandom_range(0, 14);
			end
			if (pause > 0) begin
				m_axis_tready <= 1'b0;
				repeat (pause) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			sb.check_point(m_axis_tdata, m_axis_tlast, m_axis_tuser);
		end
	end

	initial begin
		sb = new;
		sb.drop_track();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lone final point at the coordinate extremes
		send_point(32'h0000_0180, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		// same second, then time going backwards: held point only
		send_point(32'h0000_0100, 32'h0000_0000, 32'h0000_0000, 1'b0);
		send_point(32'h0000_01FF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		send_point(32'h0000_0080, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		// gap of two seconds across the full coordinate range
		send_point(32'h0000_02C0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		// exactly the gap limit, then one past it
		send_point(32'h0000_41C0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		send_point(32'h0000_8101, 32'h1234_5678, 32'hFEDC_BA98, 1'b0);
		// huge clipped gap ending the track
		send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
		// time wrapping around: hugely negative gap
		send_point(32'hFFFF_FF00, 32'h0001_0000, 32'hFFFF_0000, 1'b0);
		send_point(32'h0000_0010, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
		// one-second gap
		send_point(32'h0000_0500, 32'h0000_0010, 32'h0000_0020, 1'b0);
		send_point(32'h0000_06FF, 32'h0000_0030, 32'hFFFF_FFF0, 1'b1);
		// truncation toward zero on tiny deltas of both signs
		send_point(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
		send_point(32'h0000_0355, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
		send_point(32'h0000_0500, 32'h0000_0000, 32'h0000_0000, 1'b1);
		directed_count = sent_count;

		while (sent_count - directed_count < RANDOM_PTS)
			send_random_track();
		s_axis_tvalid <= 1'b0;
		s_axis_tlast  <= 1'b0;

		while (sb.owed_q.size() != 0) @(posedge clk);
		// nothing may trail the last owed point
		repeat (DRAIN_CYC) @(posedge clk);

		$display("run: %0d directed and %0d random points in, %0d points out",
			directed_count, sent_count - directed_count, sb.points_out);
		$display("run: %0d lone tracks, %0d clipped segments, %0d interpolated points",
			sb.lone_tracks, sb.clipped_segments, sb.fill_points);
		if (sb.errors == 0 && sb.owed_q.size() == 0) begin
			$display("track_point_linear_resampler_core: match");
		end else begin
			$display("track_point_linear_resampler_core: mismatch");
		end
		$finish;
	end

endmodule

`default_nettype wire
